// ----- design/knn_sel_pkg.sv -----
// shared types and constants for the k-th nearest neighbor selector
package knn_sel_pkg;

    localparam int KnnMaxPoints = 256;
    localparam int DistBits     = 32;
    localparam int IdxBits      = 8;
    localparam int CountBits    = $clog2(KnnMaxPoints + 1);
    localparam int RankBits     = 9;

    typedef struct packed {
        logic [IdxBits-1:0]         row_index;
        logic [IdxBits-1:0]         column_index;
        logic signed [DistBits-1:0] distance;
        logic                       distance_finite;
        logic                       row_end;
    } t_knn_in;

    typedef struct packed {
        logic [IdxBits-1:0] query_row;
        logic [IdxBits-1:0] neighbor_index;
        logic               neighbor_found;
    } t_knn_out;

    // what one cell hands to the next cell up the chain
    typedef struct packed {
        logic                lt;
        logic [DistBits-1:0] dval;
        logic [IdxBits-1:0]  col;
    } t_cell_link;

    // per-cell control from the chain owner
    typedef struct packed {
        logic en;
        logic valid;
        logic in_cap;
    } t_cell_ctl;

endpackage

// ----- design/kth_nearest_neighbor_select.sv -----
// top level of the k-th nearest neighbor selector over a streamed distance matrix
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_in_item  (t_knn_in)
//  out      | output    | o_out_valid/ i_out_stall| o_out_item (t_knn_out)
//  cfg      | input     | i_cfg_we                | i_cfg_data (neighbor rank k)
//
// an entry item is taken whenever no report is pending: it is compared against every cell of the
// chain at once and each cell either keeps, takes the new entry or takes its
// lower neighbor's entry
// an item carrying row_end is followed by a report cycle that selects the
// last kept column, loads the output register and empties the chain
// the report cycle waits while a previous result sits stalled in the output register
// synchronous active-low reset clears the fill count, rank (to 1) and handshake state;
// cell contents are only read below the fill count and need no reset
module kth_nearest_neighbor_select import knn_sel_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_knn_in             i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_knn_out            o_out_item,
    input  logic                i_cfg_we,
    input  logic [RankBits-1:0] i_cfg_data
);

    typedef enum logic {ST_ACCEPT, ST_REPORT} t_state;

    t_state               r_state;
    logic [RankBits-1:0]  r_rank;
    logic [CountBits-1:0] r_count;
    logic [IdxBits-1:0]   r_row;
    logic                 r_out_valid;
    t_knn_out             r_out;

    logic [CountBits-1:0] n_count;
    logic [CountBits-1:0] w_cap;
    logic [CountBits-1:0] w_count_eff;
    logic                 w_accept;
    logic                 w_usable;
    logic                 w_inserted;
    logic                 w_out_free;
    logic [IdxBits-1:0]   w_last_col;

    t_cell_link           w_link [KnnMaxPoints];
    t_cell_link           w_prev [KnnMaxPoints];
    t_cell_ctl            w_ctl  [KnnMaxPoints];
    logic [KnnMaxPoints-1:0] w_ins_hit;
    logic [IdxBits-1:0]   w_sel_col [KnnMaxPoints];

    // rank 0 reads as 1, anything above the chain length is cut to the chain length
    always_comb begin
        if (r_rank == '0) begin
            w_cap = CountBits'(1);
        end else if (CountBits'(r_rank) > CountBits'(KnnMaxPoints)) begin
            w_cap = CountBits'(KnnMaxPoints);
        end else begin
            w_cap = CountBits'(r_rank);
        end
    end

    // a shrunken rank trims the fill count before the next insertion
    assign w_count_eff = (r_count > w_cap) ? w_cap : r_count;

    assign o_in_stall = (r_state != ST_ACCEPT);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_usable   = (i_in_item.row_index != i_in_item.column_index)
                        && i_in_item.distance_finite && !i_in_item.distance[DistBits-1];
    assign w_out_free = !r_out_valid || !i_out_stall;

    // the chain of cells
    for (genvar gi = 0; gi < KnnMaxPoints; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_prev[gi] = '0;
        end else begin : g_body
            assign w_prev[gi] = w_link[gi-1];
        end

        assign w_ctl[gi].en     = w_accept && w_usable;
        assign w_ctl[gi].valid  = CountBits'(gi) < w_count_eff;
        assign w_ctl[gi].in_cap = CountBits'(gi) < w_cap;

        // insertion point lands inside the kept range
        assign w_ins_hit[gi] = w_ctl[gi].in_cap && w_link[gi].lt;

        // last kept slot, seen with the count after the row's final update
        assign w_sel_col[gi] = (CountBits'(gi + 1) == r_count) ? w_link[gi].col : '0;

        knn_sel_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[gi]),
            .i_new_dist (DistBits'(i_in_item.distance)),
            .i_new_col  (i_in_item.column_index),
            .i_prev     (w_prev[gi]),
            .o_link     (w_link[gi])
        );
    end

    assign w_inserted = |w_ins_hit;

    always_comb begin
        w_last_col = '0;
        for (int i = 0; i < KnnMaxPoints; i++) begin
            w_last_col = w_last_col | w_sel_col[i];
        end
    end

    always_comb begin
        n_count = w_count_eff;
        if (w_usable && w_inserted && (w_count_eff < w_cap)) begin
            n_count = w_count_eff + CountBits'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_rank      <= RankBits'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rank <= i_cfg_data;
            end
            // the report cycle reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != ST_REPORT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACCEPT: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        r_row   <= i_in_item.row_index;
                        if (i_in_item.row_end) begin
                            r_state <= ST_REPORT;
                        end
                    end
                end
                ST_REPORT: begin
                    if (w_out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.query_row      <= r_row;
                        r_out.neighbor_found <= (r_count != '0);
                        r_out.neighbor_index <= (r_count != '0) ? w_last_col : r_row;
                        r_count              <= '0;
                        r_state              <= ST_ACCEPT;
                    end
                end
                default: begin
                    r_state <= ST_ACCEPT;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountBits'(KnnMaxPoints))
        else $error("fill count beyond chain length");

    a_report_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT) |-> o_in_stall)
        else $error("item taken during report cycle");

    a_report_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT && w_out_free) |=> (r_out_valid && r_count == '0))
        else $error("report did not load output and empty the chain");

    a_row_end_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.row_end) |=> (r_state == ST_REPORT))
        else $error("row end item did not start a report");

endmodule

// ----- design/knn_sel_cell.sv -----
// one slot of the sorted insertion chain
module knn_sel_cell import knn_sel_pkg::*; (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [DistBits-1:0] i_new_dist,
    input  logic [IdxBits-1:0]  i_new_col,
    input  t_cell_link          i_prev,
    output t_cell_link          o_link
);

    logic [DistBits-1:0] r_dist;
    logic [IdxBits-1:0]  r_col;
    logic                w_before;

    // strict order: distance first, then column
    assign w_before = (i_new_dist != r_dist) ? (i_new_dist < r_dist) : (i_new_col < r_col);

    assign o_link.lt   = !i_ctl.valid || w_before;
    assign o_link.dval = r_dist;
    assign o_link.col  = r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.in_cap) begin
            if (i_prev.lt) begin
                r_dist <= i_prev.dval;
                r_col  <= i_prev.col;
            end else if (o_link.lt) begin
                r_dist <= i_new_dist;
                r_col  <= i_new_col;
            end
        end
    end

endmodule
